// File: rtl/pse_pkg.sv
// Shared types and constants of the postfix stack evaluator.
`default_nettype none
package pse_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned DVD_W  = DATA_W + FRAC_W;
  localparam int unsigned DVS_W  = DATA_W;

  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4
  } cmd_e_t;

  typedef struct packed {
    logic saturated;
    logic divide_by_zero;
    logic overflow;
    logic underflow;
  } flags_t;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_POP_R    = 11'b000_0000_0010,
    S_POP_L    = 11'b000_0000_0100,
    S_EXEC     = 11'b000_0000_1000,
    S_ALU      = 11'b000_0001_0000,
    S_MUL      = 11'b000_0010_0000,
    S_DIV      = 11'b000_0100_0000,
    S_PUSH     = 11'b000_1000_0000,
    S_FIN      = 11'b001_0000_0000,
    S_FIN_WAIT = 11'b010_0000_0000,
    S_OUT      = 11'b100_0000_0000
  } state_t;

endpackage
`default_nettype wire

// File: rtl/pse_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module pse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/pse_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module pse_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [pse_pkg::DVD_W-1:0]      dividend,
  input  wire logic [pse_pkg::DVS_W-1:0]      divisor,
  output logic                                done,
  output logic      [pse_pkg::DVD_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(pse_pkg::DVD_W);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [pse_pkg::DVS_W-1:0]   rem_r;
  logic [pse_pkg::DVS_W-1:0]   dvs_r;
  logic [pse_pkg::DVD_W-1:0]   quo_r;
  logic [pse_pkg::DVS_W:0]     rem_sh;
  logic [pse_pkg::DVS_W:0]     diff;
  logic                        take;

  assign rem_sh = {rem_r, quo_r[pse_pkg::DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign take   = ~diff[pse_pkg::DVS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(pse_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? diff[pse_pkg::DVS_W-1:0] : rem_sh[pse_pkg::DVS_W-1:0];
      quo_r <= {quo_r[pse_pkg::DVD_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// File: rtl/postfix_stack_evaluator.sv
// Postfix expression evaluator: operand stack in RAM, Q16.16 arithmetic unit.
//
// Tokens arrive on the in_ stream (tuser = command, tdata = Q16.16 operand,
// tlast = end of expression); the result of each expression leaves on the
// out_ stream with its sticky flags. One token is worked on at a time, with
// each stack pop a registered read of the stack RAM. A push is written
// straight from the input, while divide waits on the 48-step restoring
// divider (a zero divisor skips it). A token marked last then passes
// through S_FIN, S_FIN_WAIT and S_OUT for the final pop and the output
// load. The output register lets the next token be taken while a result
// still waits; a further result stalls only until the first is taken.
`default_nettype none
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] operand_value
  input  wire logic [2:0]  in_tuser,   // [2:0] command
  input  wire logic        in_tlast,   // end_of_expression
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [31:0] result_value
  output logic      [3:0]  out_tuser   // [0] underflow [1] overflow [2] divide_by_zero [3] saturated
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW = pse_pkg::DATA_W;

  pse_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  pse_pkg::flags_t flags_r, flags_nxt;
  pse_pkg::cmd_e_t cmd_r, cmd_nxt;
  logic            last_r, last_nxt;
  logic            hit_r, hit_nxt;
  logic            neg_r, neg_nxt;
  logic [DW-1:0]   rgt_r, rgt_nxt;
  logic [DW-1:0]   lft_r, lft_nxt;
  logic [DW-1:0]   res_r, res_nxt;
  logic signed [2*DW-1:0] prod_r, prod_nxt;

  logic            out_tvalid_r;
  logic [DW-1:0]   out_tdata_r;
  pse_pkg::flags_t out_tuser_r;
  logic            out_load;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [DW-1:0]   mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [DW-1:0]   mem_rdata;

  logic                          div_start;
  logic                          div_done;
  logic [pse_pkg::DVD_W-1:0]     div_quo;
  logic [DW-1:0]                 mag_l;
  logic [DW-1:0]                 mag_r;

  logic [CW-1:0]   count_dec;
  logic            st_full;
  logic            st_empty;
  logic [DW:0]     sum;
  logic [DW:0]     dif;
  logic            mul_fits;

  assign count_dec = count_r - 1'b1;
  assign st_full   = count_r >= CW'(STACK_DEPTH);
  assign st_empty  = count_r == '0;
  assign mem_raddr = count_dec[AW-1:0];
  assign sum       = {lft_r[DW-1], lft_r} + {rgt_r[DW-1], rgt_r};
  assign dif       = {lft_r[DW-1], lft_r} - {rgt_r[DW-1], rgt_r};
  assign mul_fits  = (&prod_r[2*DW-1:DW+pse_pkg::FRAC_W-1])
                   | ~(|prod_r[2*DW-1:DW+pse_pkg::FRAC_W-1]);
  assign mag_l     = lft_r[DW-1] ? (~lft_r + 1'b1) : lft_r;
  assign mag_r     = rgt_r[DW-1] ? (~rgt_r + 1'b1) : rgt_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    flags_nxt     = flags_r;
    cmd_nxt       = cmd_r;
    last_nxt      = last_r;
    hit_nxt       = hit_r;
    neg_nxt       = neg_r;
    rgt_nxt       = rgt_r;
    lft_nxt       = lft_r;
    res_nxt       = res_r;
    prod_nxt      = prod_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = res_r;
    mem_re        = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    in_tready     = state_r == pse_pkg::S_IDLE;

    case (state_r)
      pse_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt  = pse_pkg::cmd_e_t'(in_tuser);
          last_nxt = in_tlast;
          case (pse_pkg::cmd_e_t'(in_tuser))
            pse_pkg::CMD_PUSH: begin
              if (!st_full) begin
                mem_we    = 1'b1;
                mem_wdata = in_tdata;
                count_nxt = count_r + 1'b1;
              end else begin
                flags_nxt.overflow = 1'b1;
              end
              state_nxt = in_tlast ? pse_pkg::S_FIN : pse_pkg::S_IDLE;
            end
            pse_pkg::CMD_ADD, pse_pkg::CMD_SUB,
            pse_pkg::CMD_MUL, pse_pkg::CMD_DIV: begin
              state_nxt = pse_pkg::S_POP_R;
            end
            default: begin
              state_nxt = in_tlast ? pse_pkg::S_FIN : pse_pkg::S_IDLE;
            end
          endcase
        end
      end
      pse_pkg::S_POP_R, pse_pkg::S_POP_L, pse_pkg::S_FIN: begin
        if (state_r == pse_pkg::S_POP_L) begin
          rgt_nxt = hit_r ? mem_rdata : '0;
        end
        if (st_empty) begin
          flags_nxt.underflow = 1'b1;
          hit_nxt             = 1'b0;
        end else begin
          mem_re    = 1'b1;
          count_nxt = count_dec;
          hit_nxt   = 1'b1;
        end
        case (state_r)
          pse_pkg::S_POP_R: state_nxt = pse_pkg::S_POP_L;
          pse_pkg::S_POP_L: state_nxt = pse_pkg::S_EXEC;
          default:          state_nxt = pse_pkg::S_FIN_WAIT;
        endcase
      end
      pse_pkg::S_EXEC: begin
        lft_nxt   = hit_r ? mem_rdata : '0;
        state_nxt = pse_pkg::S_ALU;
      end
      pse_pkg::S_ALU: begin
        state_nxt = pse_pkg::S_PUSH;
        case (cmd_r)
          pse_pkg::CMD_ADD: begin
            if (sum[DW] != sum[DW-1]) begin
              res_nxt              = sum[DW] ? pse_pkg::Q_MIN : pse_pkg::Q_MAX;
              flags_nxt.saturated  = 1'b1;
            end else begin
              res_nxt = sum[DW-1:0];
            end
          end
          pse_pkg::CMD_SUB: begin
            if (dif[DW] != dif[DW-1]) begin
              res_nxt              = dif[DW] ? pse_pkg::Q_MIN : pse_pkg::Q_MAX;
              flags_nxt.saturated  = 1'b1;
            end else begin
              res_nxt = dif[DW-1:0];
            end
          end
          pse_pkg::CMD_MUL: begin
            prod_nxt  = $signed(lft_r) * $signed(rgt_r);
            state_nxt = pse_pkg::S_MUL;
          end
          pse_pkg::CMD_DIV: begin
            neg_nxt = lft_r[DW-1] ^ rgt_r[DW-1];
            if (rgt_r == '0) begin
              res_nxt                  = lft_r[DW-1] ? pse_pkg::Q_MIN : pse_pkg::Q_MAX;
              flags_nxt.divide_by_zero = 1'b1;
            end else begin
              div_start = 1'b1;
              state_nxt = pse_pkg::S_DIV;
            end
          end
          default: begin
            res_nxt = res_r;
          end
        endcase
      end
      pse_pkg::S_MUL: begin
        if (mul_fits) begin
          res_nxt = prod_r[DW+pse_pkg::FRAC_W-1:pse_pkg::FRAC_W];
        end else begin
          res_nxt             = prod_r[2*DW-1] ? pse_pkg::Q_MIN : pse_pkg::Q_MAX;
          flags_nxt.saturated = 1'b1;
        end
        state_nxt = pse_pkg::S_PUSH;
      end
      pse_pkg::S_DIV: begin
        if (div_done) begin
          if (!neg_r) begin
            if (|div_quo[pse_pkg::DVD_W-1:DW-1]) begin
              res_nxt             = pse_pkg::Q_MAX;
              flags_nxt.saturated = 1'b1;
            end else begin
              res_nxt = div_quo[DW-1:0];
            end
          end else begin
            if ((|div_quo[pse_pkg::DVD_W-1:DW])
                || (div_quo[DW-1] && (|div_quo[DW-2:0]))) begin
              res_nxt             = pse_pkg::Q_MIN;
              flags_nxt.saturated = 1'b1;
            end else begin
              res_nxt = ~div_quo[DW-1:0] + 1'b1;
            end
          end
          state_nxt = pse_pkg::S_PUSH;
        end
      end
      pse_pkg::S_PUSH: begin
        if (!st_full) begin
          mem_we    = 1'b1;
          count_nxt = count_r + 1'b1;
        end else begin
          flags_nxt.overflow = 1'b1;
        end
        state_nxt = last_r ? pse_pkg::S_FIN : pse_pkg::S_IDLE;
      end
      pse_pkg::S_FIN_WAIT: begin
        res_nxt   = hit_r ? mem_rdata : '0;
        state_nxt = pse_pkg::S_OUT;
      end
      pse_pkg::S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          count_nxt = '0;
          flags_nxt = '0;
          state_nxt = pse_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pse_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pse_pkg::S_IDLE;
      count_r      <= '0;
      flags_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      flags_r <= flags_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    last_r <= last_nxt;
    hit_r  <= hit_nxt;
    neg_r  <= neg_nxt;
    rgt_r  <= rgt_nxt;
    lft_r  <= lft_nxt;
    res_r  <= res_nxt;
    prod_r <= prod_nxt;
    if (out_load) begin
      out_tdata_r <= res_r;
      out_tuser_r <= flags_r;
    end
  end

  pse_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({mag_l, {pse_pkg::FRAC_W{1'b0}}}),
    .divisor  (mag_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re && (mem_waddr == mem_raddr)))
    else $error("stack RAM read and write to the same entry");

  a_clear_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (count_r == '0) && (flags_r == '0) && out_tvalid)
    else $error("stack not cleared after result beat");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == pse_pkg::S_DIV))
    else $error("divider finished outside divide wait");
`endif

endmodule
`default_nettype wire
